### design/tcmp_pkg.sv
// shared types, constants and register map for the triggered capture block
package tcmp_pkg;

	localparam int MAX_DEPTH   = 65536;
	localparam int LEVELS      = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int IDX_W       = $clog2(MAX_DEPTH);
	localparam int LEN_W       = IDX_W + 1;
	localparam int LVL_W       = 3;
	localparam int CMD_DEPTH   = 4;
	localparam int OUT_DEPTH   = 4;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_LENGTH = 3'd0;
	localparam logic [2:0] REG_LEVELS = 3'd1;
	localparam logic [2:0] REG_TRIG_HI = 3'd2;
	localparam logic [2:0] REG_TRIG_LO = 3'd3;
	localparam logic [2:0] REG_PULSE  = 3'd4;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_STORE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		op_t              operation;
		sample_t          signal_sample;
		sample_t          trigger_sample;
		logic             manual_start;
		logic [LVL_W-1:0] read_level;
		logic [IDX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic    capturing;
		logic    captured;
		logic    trigger_pulse;
		sample_t capture_min;
		sample_t capture_max;
		sample_t read_min;
		sample_t read_max;
		logic    read_valid;
	} out_item_t;

	// status known at the front when the transaction is accepted
	typedef struct packed {
		logic    capturing;
		logic    captured;
		logic    trigger_pulse;
		sample_t capture_min;
		sample_t capture_max;
	} status_t;

	// work handed from the front to the back
	typedef struct packed {
		cmd_kind_t        kind;
		sample_t          sample;
		logic [IDX_W-1:0] widx;
		logic [LVL_W-1:0] lvl_cnt;
		logic [LVL_W-1:0] read_level;
		logic [IDX_W-1:0] read_index;
		logic             read_ok;
		status_t          status;
	} cmd_t;

endpackage

### design/triggered_capture_minmax_pyramid.sv
// top level: triggered capture store with min/max pyramid
//
// channel   direction  handshake             payload
// input     in         push / full           in_item (tcmp_pkg::in_item_t)
// result    out        empty / pop           out_item (tcmp_pkg::out_item_t)
// config    in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// one transaction a cycle is taken while the command queue has room; each
// gives one result, through the command queue and the registered memory read
// reset clears control state; sample and pyramid memories hold garbage
// until written, and the pyramid tracks each group in a running register
// the result queue is four deep; commands wait in their queue while it fills
module triggered_capture_minmax_pyramid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  tcmp_pkg::in_item_t            in_item,
	output logic                          empty,
	input  logic                          pop,
	output tcmp_pkg::out_item_t           out_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcmp_pkg::ADDR_W-1:0]   paddr,
	input  logic [tcmp_pkg::DATA_W-1:0]   pwdata,
	output logic [tcmp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	logic           cmd_push;
	logic           cmd_full;
	logic           cmd_pop;
	logic           cmd_empty;
	tcmp_pkg::cmd_t cmd_in;
	tcmp_pkg::cmd_t cmd_out;

	assign pready = 1'b1;

	// classify and control
	tcmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	// decoupling queue
	tcmp_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// memories and results
	tcmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

### design/tcmp_cmd_fifo.sv
// short command queue between the front and the back
module tcmp_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  tcmp_pkg::cmd_t  wr_data,
	output logic            full,
	input  logic            rd_en,
	output tcmp_pkg::cmd_t  rd_data,
	output logic            empty
);
	localparam int PW = $clog2(tcmp_pkg::CMD_DEPTH);

	tcmp_pkg::cmd_t  mem_q [tcmp_pkg::CMD_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = (count_q == (PW+1)'(tcmp_pkg::CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(wr_en && !full) - (PW+1)'(rd_en && !empty);
		end
	end

endmodule

### design/tcmp_front.sv
// front: register port, trigger and capture control, command issue
module tcmp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  tcmp_pkg::in_item_t            in_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcmp_pkg::ADDR_W-1:0]   paddr,
	input  logic [tcmp_pkg::DATA_W-1:0]   pwdata,
	output logic [tcmp_pkg::DATA_W-1:0]   prdata,
	output logic                          cmd_push,
	output tcmp_pkg::cmd_t                cmd,
	input  logic                          cmd_full
);
	localparam int SB = tcmp_pkg::SAMPLE_BITS;
	localparam int LW = tcmp_pkg::LEN_W;
	localparam tcmp_pkg::sample_t SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam tcmp_pkg::sample_t SMIN = {1'b1, {(SB-1){1'b0}}};

	// configuration registers
	logic [LW-1:0]                len_q;
	logic [tcmp_pkg::LVL_W-1:0]   lvl_q;
	tcmp_pkg::sample_t            thr_hi_q;
	tcmp_pkg::sample_t            thr_lo_q;
	logic [15:0]                  pulse_len_q;

	// capture state
	logic [tcmp_pkg::IDX_W-1:0]   widx_q;
	logic                         active_q;
	logic                         done_q;
	logic                         schmitt_q;
	logic [15:0]                  pulse_q;
	tcmp_pkg::sample_t            rmin_q;
	tcmp_pkg::sample_t            rmax_q;

	logic                         cfg_wr;
	logic [2:0]                   reg_sel;
	logic                         accept;
	logic [LW-1:0]                eff_len;
	logic [tcmp_pkg::LVL_W-1:0]   eff_lc;
	logic [LW:0]                  used;
	logic [LW-1:0]                widx_inc;

	logic                         active_d, done_d, schmitt_d, fired, pulse_out;
	logic [15:0]                  pulse_d;
	tcmp_pkg::sample_t            rmin_d, rmax_d;
	logic [tcmp_pkg::IDX_W-1:0]   widx_d;
	logic                         read_ok;

	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[4:2];
	assign full    = cmd_full;
	assign accept  = push && !cmd_full;

	// register readback
	always_comb begin
		prdata = '0;
		case (reg_sel)
			tcmp_pkg::REG_LENGTH:  prdata = tcmp_pkg::DATA_W'(len_q);
			tcmp_pkg::REG_LEVELS:  prdata = tcmp_pkg::DATA_W'(lvl_q);
			tcmp_pkg::REG_TRIG_HI: prdata = tcmp_pkg::DATA_W'($unsigned(thr_hi_q));
			tcmp_pkg::REG_TRIG_LO: prdata = tcmp_pkg::DATA_W'($unsigned(thr_lo_q));
			tcmp_pkg::REG_PULSE:   prdata = tcmp_pkg::DATA_W'(pulse_len_q);
			default:               prdata = '0;
		endcase
	end

	// effective length and level count
	always_comb begin
		if (len_q == '0) begin
			eff_len = LW'(1);
		end else if (len_q > LW'(tcmp_pkg::MAX_DEPTH)) begin
			eff_len = LW'(tcmp_pkg::MAX_DEPTH);
		end else begin
			eff_len = len_q;
		end
		eff_lc = (lvl_q > tcmp_pkg::LVL_W'(tcmp_pkg::LEVELS)) ?
			tcmp_pkg::LVL_W'(tcmp_pkg::LEVELS) : lvl_q;
	end

	// used entries of the requested pyramid level
	always_comb begin
		used = '0;
		for (int l = 1; l <= tcmp_pkg::LEVELS; l++) begin
			if (in_item.read_level == tcmp_pkg::LVL_W'(l)) begin
				used = ({1'b0, eff_len} + (LW+1)'((1 << (2*l)) - 1)) >> (2*l);
			end
		end
	end

	// read range check
	always_comb begin
		if (in_item.read_level == '0) begin
			read_ok = ({1'b0, in_item.read_index} < eff_len);
		end else begin
			read_ok = (in_item.read_level <= eff_lc) &&
				((LW+1)'(in_item.read_index) < used);
		end
	end

	assign widx_inc = {1'b0, widx_q} + LW'(1);

	// tick update: arm, pulse, store, end of capture
	always_comb begin
		active_d  = active_q;
		done_d    = done_q;
		schmitt_d = schmitt_q;
		rmin_d    = rmin_q;
		rmax_d    = rmax_q;
		widx_d    = widx_q;
		pulse_d   = pulse_q;
		fired     = 1'b0;
		if (!active_q) begin
			if (schmitt_q) begin
				if (in_item.trigger_sample <= thr_lo_q) begin
					schmitt_d = 1'b0;
				end
			end else if (in_item.trigger_sample >= thr_hi_q) begin
				schmitt_d = 1'b1;
				fired     = 1'b1;
			end
			if (in_item.manual_start) begin
				fired = 1'b1;
			end
			if (fired) begin
				active_d = 1'b1;
				rmin_d   = SMAX;
				rmax_d   = SMIN;
				if (pulse_len_q > pulse_q) begin
					pulse_d = pulse_len_q;
				end
			end
		end
		pulse_out = (pulse_d != '0);
		if (pulse_out) begin
			pulse_d = pulse_d - 16'd1;
		end
		if (active_d) begin
			schmitt_d = 1'b1;
			if (in_item.signal_sample < rmin_d) begin
				rmin_d = in_item.signal_sample;
			end
			if (in_item.signal_sample > rmax_d) begin
				rmax_d = in_item.signal_sample;
			end
			widx_d = widx_inc[tcmp_pkg::IDX_W-1:0];
			if (widx_inc >= eff_len) begin
				done_d   = 1'b1;
				active_d = 1'b0;
				widx_d   = '0;
			end
		end
	end

	// command to the back
	always_comb begin
		cmd            = '0;
		cmd.sample     = in_item.signal_sample;
		cmd.widx       = widx_q;
		cmd.lvl_cnt    = eff_lc;
		cmd.read_level = in_item.read_level;
		cmd.read_index = in_item.read_index;
		if (in_item.operation == tcmp_pkg::OP_READ) begin
			cmd.kind                 = tcmp_pkg::CMD_READ;
			cmd.read_ok              = read_ok;
			cmd.status.capturing     = active_q;
			cmd.status.captured      = done_q;
			cmd.status.trigger_pulse = (pulse_q != '0);
			cmd.status.capture_min   = rmin_q;
			cmd.status.capture_max   = rmax_q;
		end else begin
			cmd.kind                 = (active_q || fired) ? tcmp_pkg::CMD_STORE :
				tcmp_pkg::CMD_NONE;
			cmd.read_ok              = 1'b0;
			cmd.status.capturing     = active_q || fired;
			cmd.status.captured      = done_d;
			cmd.status.trigger_pulse = pulse_out;
			cmd.status.capture_min   = rmin_d;
			cmd.status.capture_max   = rmax_d;
		end
	end
	assign cmd_push = accept;

	// configuration and capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LW'(tcmp_pkg::MAX_DEPTH);
			lvl_q       <= tcmp_pkg::LVL_W'(tcmp_pkg::LEVELS);
			thr_hi_q    <= SB'(5120);
			thr_lo_q    <= SB'(4915);
			pulse_len_q <= 16'd441;
			widx_q      <= '0;
			active_q    <= 1'b0;
			done_q      <= 1'b0;
			schmitt_q   <= 1'b1;
			pulse_q     <= '0;
			rmin_q      <= SMAX;
			rmax_q      <= SMIN;
		end else if (cfg_wr) begin
			case (reg_sel)
				tcmp_pkg::REG_LENGTH:  len_q       <= pwdata[LW-1:0];
				tcmp_pkg::REG_LEVELS:  lvl_q       <= pwdata[tcmp_pkg::LVL_W-1:0];
				tcmp_pkg::REG_TRIG_HI: thr_hi_q    <= pwdata[SB-1:0];
				tcmp_pkg::REG_TRIG_LO: thr_lo_q    <= pwdata[SB-1:0];
				tcmp_pkg::REG_PULSE:   pulse_len_q <= pwdata[15:0];
				default: ;
			endcase
			if (reg_sel == tcmp_pkg::REG_LENGTH || reg_sel == tcmp_pkg::REG_LEVELS) begin
				widx_q    <= '0;
				active_q  <= 1'b0;
				done_q    <= 1'b0;
				schmitt_q <= 1'b1;
				rmin_q    <= SMAX;
				rmax_q    <= SMIN;
			end
		end else if (accept && in_item.operation == tcmp_pkg::OP_TICK) begin
			widx_q    <= widx_d;
			active_q  <= active_d;
			done_q    <= done_d;
			schmitt_q <= schmitt_d;
			pulse_q   <= pulse_d;
			rmin_q    <= rmin_d;
			rmax_q    <= rmax_d;
		end
	end

	// clearing write stops any capture
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_sel == tcmp_pkg::REG_LENGTH) |=> (!active_q && !done_q))
		else $error("capture not cleared by length write");

	// write index stays inside the capture
	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ({1'b0, widx_q} < eff_len))
		else $error("write index beyond capture length");

	// a capturing tick leaves the trigger high
	a_schmitt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.operation == tcmp_pkg::OP_TICK && active_q && !cfg_wr)
		|=> schmitt_q)
		else $error("trigger state not held during capture");

endmodule

### design/tcmp_back.sv
// back: sample and pyramid memories, result assembly and result queue
module tcmp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcmp_pkg::cmd_t      cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output tcmp_pkg::out_item_t out_item
);
	localparam int SB = tcmp_pkg::SAMPLE_BITS;
	localparam int LV = tcmp_pkg::LEVELS;
	localparam int PW = $clog2(tcmp_pkg::OUT_DEPTH);

	logic                       do_store;
	logic                       do_read;
	tcmp_pkg::sample_t          sample_mem [tcmp_pkg::MAX_DEPTH];
	tcmp_pkg::sample_t          sample_rd_s2;
	logic [2*SB-1:0]            lvl_rd_s2 [1:LV];
	logic                       valid_s2;
	logic                       ok_s2;
	logic [tcmp_pkg::LVL_W-1:0] lvl_s2;
	tcmp_pkg::status_t          status_s2;
	tcmp_pkg::out_item_t        result;

	tcmp_pkg::out_item_t        out_mem_q [tcmp_pkg::OUT_DEPTH];
	logic [PW-1:0]              wr_ptr_q;
	logic [PW-1:0]              rd_ptr_q;
	logic [PW:0]                count_q;

	// take a command only when its result has a slot
	assign cmd_pop  = !cmd_empty &&
		((count_q + (PW+1)'(valid_s2)) < (PW+1)'(tcmp_pkg::OUT_DEPTH));
	assign do_store = cmd_pop && cmd.kind == tcmp_pkg::CMD_STORE;
	assign do_read  = cmd_pop && cmd.kind == tcmp_pkg::CMD_READ;

	// raw sample memory
	always_ff @(posedge clk) begin
		if (do_store) begin
			sample_mem[cmd.widx] <= cmd.sample;
		end
		if (do_read) begin
			sample_rd_s2 <= sample_mem[cmd.read_index];
		end
	end

	// one memory per pyramid level, group min/max kept in a running register
	for (genvar k = 1; k <= LV; k++) begin : g_level
		localparam int DK = tcmp_pkg::MAX_DEPTH >> (2*k);
		localparam int AW = tcmp_pkg::IDX_W - 2*k;
		logic [2*SB-1:0]   mem [DK];
		tcmp_pkg::sample_t acc_min_q, acc_max_q;
		tcmp_pkg::sample_t new_min, new_max;
		logic              first;
		logic              en;

		assign first = (cmd.widx[2*k-1:0] == '0);
		assign en    = do_store && (cmd.lvl_cnt >= tcmp_pkg::LVL_W'(k));

		always_comb begin
			new_min = cmd.sample;
			new_max = cmd.sample;
			if (!first) begin
				if (acc_min_q < cmd.sample) begin
					new_min = acc_min_q;
				end
				if (acc_max_q > cmd.sample) begin
					new_max = acc_max_q;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_min_q                                 <= new_min;
				acc_max_q                                 <= new_max;
				mem[cmd.widx[tcmp_pkg::IDX_W-1:2*k]]      <= {new_min, new_max};
			end
			if (do_read) begin
				lvl_rd_s2[k] <= mem[cmd.read_index[AW-1:0]];
			end
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= cmd_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ok_s2     <= cmd.read_ok;
			lvl_s2    <= cmd.read_level;
			status_s2 <= cmd.status;
		end
	end

	// result assembly
	always_comb begin
		result               = '0;
		result.capturing     = status_s2.capturing;
		result.captured      = status_s2.captured;
		result.trigger_pulse = status_s2.trigger_pulse;
		result.capture_min   = status_s2.capture_min;
		result.capture_max   = status_s2.capture_max;
		result.read_valid    = ok_s2;
		if (ok_s2) begin
			if (lvl_s2 == '0) begin
				result.read_min = sample_rd_s2;
				result.read_max = sample_rd_s2;
			end
			for (int k = 1; k <= LV; k++) begin
				if (lvl_s2 == tcmp_pkg::LVL_W'(k)) begin
					result.read_min = lvl_rd_s2[k][2*SB-1:SB];
					result.read_max = lvl_rd_s2[k][SB-1:0];
				end
			end
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			out_mem_q[wr_ptr_q] <= result;
		end
	end

	assign empty    = (count_q == '0);
	assign out_item = out_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(valid_s2) - (PW+1)'(pop && !empty);
		end
	end

	// result queue never overfills
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(tcmp_pkg::OUT_DEPTH))
		else $error("result queue overflow");

	// a finished result is visible next cycle
	a_out_push: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |=> (count_q != '0))
		else $error("result lost");

	// issue only with a free slot
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> ((count_q + (PW+1)'(valid_s2)) < (PW+1)'(tcmp_pkg::OUT_DEPTH)))
		else $error("command issued without result slot");

endmodule

### tb/sv/tcmp_checker.sv
// checker for the triggered capture block: watches all channels, predicts and compares
`timescale 1ns / 1ps
module tcmp_checker
	import tcmp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  in_item_t            in_item,
	input  logic                empty,
	input  logic                pop,
	input  out_item_t           out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output int                  fail_count,
	output int                  pending,
	// written high-water marks: entry 0 raw samples, entry k pyramid level k
	output logic [4:0][16:0]    marks
);

	localparam int LVL_SPACE = MAX_DEPTH / 3 + LEVELS + 1;

	// predictor state
	sample_t   raw_mem [0:MAX_DEPTH-1];
	sample_t   lvl_min [0:LVL_SPACE-1];
	sample_t   lvl_max [0:LVL_SPACE-1];
	int        wr_idx;
	logic      active, done, sch_high;
	int        pulse_left;
	sample_t   run_min, run_max;
	int        cfg_len, cfg_lvls, cfg_pulse;
	sample_t   cfg_hi, cfg_lo;
	out_item_t results_due[$];

	function automatic int len_eff();
		if (cfg_len == 0) return 1;
		if (cfg_len > MAX_DEPTH) return MAX_DEPTH;
		return cfg_len;
	endfunction

	function automatic int lvls_eff();
		return (cfg_lvls > LEVELS) ? LEVELS : cfg_lvls;
	endfunction

	function automatic int lvl_base(int k);
		int b;
		b = 0;
		for (int j = 1; j < k; j++) b += MAX_DEPTH >> (2 * j);
		return b;
	endfunction

	task automatic clear_capture();
		wr_idx = 0;
		active = 0;
		done = 0;
		sch_high = 1;
		run_min = 16'sh7fff;
		run_max = 16'sh8000;
	endtask

	// store one sample into raw memory, running min/max and the pyramid
	task automatic store_sample(sample_t v);
		int pos;
		logic first;
		if (wr_idx >= MAX_DEPTH) return;
		raw_mem[wr_idx] = v;
		if (wr_idx + 1 > marks[0]) marks[0] = 17'(wr_idx + 1);
		if (v < run_min) run_min = v;
		if (v > run_max) run_max = v;
		for (int k = 1; k <= lvls_eff(); k++) begin
			pos = lvl_base(k) + (wr_idx >> (2 * k));
			first = (wr_idx & ((1 << (2 * k)) - 1)) == 0;
			if (pos >= LVL_SPACE) continue;
			if ((wr_idx >> (2 * k)) + 1 > marks[k]) marks[k] = 17'((wr_idx >> (2 * k)) + 1);
			if (first) begin
				lvl_min[pos] = v;
				lvl_max[pos] = v;
			end else begin
				if (v < lvl_min[pos]) lvl_min[pos] = v;
				if (v > lvl_max[pos]) lvl_max[pos] = v;
			end
		end
		wr_idx++;
	endtask

	// compute the result of one accepted transaction and advance the state
	task automatic capture_step(input in_item_t it, output out_item_t r);
		logic fired;
		int lvl, idx, used, pos;
		r = '0;
		if (it.operation == OP_TICK) begin
			if (!active) begin
				fired = 0;
				if (sch_high) begin
					if (it.trigger_sample <= cfg_lo) sch_high = 0;
				end else if (it.trigger_sample >= cfg_hi) begin
					sch_high = 1;
					fired = 1;
				end
				if (it.manual_start) fired = 1;
				if (fired) begin
					active = 1;
					run_min = 16'sh7fff;
					run_max = 16'sh8000;
					if (cfg_pulse > pulse_left) pulse_left = cfg_pulse;
				end
			end
			r.capturing = active;
			r.trigger_pulse = pulse_left != 0;
			if (pulse_left != 0) pulse_left--;
			if (active) begin
				sch_high = 1;
				store_sample(it.signal_sample);
				if (wr_idx >= len_eff()) begin
					done = 1;
					active = 0;
					wr_idx = 0;
				end
			end
		end else begin
			lvl = it.read_level;
			idx = it.read_index;
			r.capturing = active;
			r.trigger_pulse = pulse_left != 0;
			if (lvl == 0) begin
				if (idx < len_eff()) begin
					r.read_valid = 1;
					r.read_min = raw_mem[idx];
					r.read_max = raw_mem[idx];
				end
			end else if (lvl <= lvls_eff()) begin
				used = (len_eff() + (1 << (2 * lvl)) - 1) >> (2 * lvl);
				pos = lvl_base(lvl) + idx;
				if (idx < used && pos < LVL_SPACE) begin
					r.read_valid = 1;
					r.read_min = lvl_min[pos];
					r.read_max = lvl_max[pos];
				end
			end
		end
		r.captured = done;
		r.capture_min = run_min;
		r.capture_max = run_max;
	endtask

	task automatic report(string what, out_item_t exp_r, out_item_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch %s: expected %p actual %p", $realtime, what, exp_r, got);
	endtask

	// watch config, input and result channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t r, exp_r;
		if (!arst_n) begin
			cfg_len = MAX_DEPTH;
			cfg_lvls = 4;
			cfg_hi = 16'sd5120;
			cfg_lo = 16'sd4915;
			cfg_pulse = 441;
			pulse_left = 0;
			clear_capture();
			results_due.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_LENGTH: begin
						cfg_len = pwdata & 32'h1ffff;
						clear_capture();
					end
					REG_LEVELS: begin
						cfg_lvls = pwdata & 32'h7;
						clear_capture();
					end
					REG_TRIG_HI: cfg_hi = pwdata[15:0];
					REG_TRIG_LO: cfg_lo = pwdata[15:0];
					REG_PULSE:   cfg_pulse = pwdata[15:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				capture_step(in_item, r);
				results_due = {results_due, r};
			end
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					report("unexpected result", '0, out_item);
				end else begin
					exp_r = results_due.pop_front();
					if (out_item.capturing !== exp_r.capturing ||
					    out_item.captured !== exp_r.captured ||
					    out_item.trigger_pulse !== exp_r.trigger_pulse ||
					    out_item.capture_min !== exp_r.capture_min ||
					    out_item.capture_max !== exp_r.capture_max ||
					    out_item.read_min !== exp_r.read_min ||
					    out_item.read_max !== exp_r.read_max ||
					    out_item.read_valid !== exp_r.read_valid)
						report("result field", exp_r, out_item);
				end
			end
			pending = results_due.size();
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		marks = '0;
	end

endmodule

### tb/sv/tb.sv
// testbench top: stimulus, config phases and verdict for the triggered capture block
`timescale 1ns / 1ps
module tb;
	import tcmp_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic                clk, arst_n;
	logic                push, full, empty, pop;
	in_item_t            in_item;
	out_item_t           out_item;
	logic                psel, penable, pwrite, pready;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata, prdata;
	int                  fail_count, pending, idle_cycles;
	logic [4:0][16:0]    marks;
	int                  cfg_len, cfg_lvls, cfg_hi, cfg_lo;
	logic                gaps_on;

	triggered_capture_minmax_pyramid u_top (.*);

	tcmp_checker u_chk (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls between pops
	initial begin
		int n;
		pop <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			n = gaps_on ? $urandom_range(0, 7) : 0;
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send(in_item_t it);
		int n;
		n = gaps_on ? $urandom_range(0, 7) : 0;
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// let every expected result drain, then wait for the pipeline to empty
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic configure(int len, int lvls, int hi, int lo, int pulse);
		drain();
		reg_write(REG_LENGTH, len);
		reg_write(REG_LEVELS, lvls);
		reg_write(REG_TRIG_HI, hi & 16'hffff);
		reg_write(REG_TRIG_LO, lo & 16'hffff);
		reg_write(REG_PULSE, pulse);
		cfg_len = (len == 0) ? 1 : (len > MAX_DEPTH ? MAX_DEPTH : len);
		cfg_lvls = (lvls > LEVELS) ? LEVELS : lvls;
		cfg_hi = hi;
		cfg_lo = lo;
	endtask

	function automatic int used_size(int lvl);
		return (cfg_len + (1 << (2 * lvl)) - 1) >> (2 * lvl);
	endfunction

	task automatic tick(int sig, int trg, logic ms);
		in_item_t it;
		it = '0;
		it.operation = OP_TICK;
		it.signal_sample = sig;
		it.trigger_sample = trg;
		it.manual_start = ms;
		it.read_level = $urandom;
		it.read_index = $urandom;
		send(it);
	endtask

	// reads are steered away from entries that were never written
	task automatic read_at(int lvl, int idx);
		in_item_t it;
		int used, lim;
		used = (lvl == 0) ? cfg_len : used_size(lvl);
		if (lvl <= cfg_lvls && idx < used && idx >= marks[lvl]) begin
			lim = (marks[lvl] < used) ? marks[lvl] : used;
			if (lim > 0) idx = $urandom_range(0, lim - 1);
			else lvl = 7;
		end
		it = '0;
		it.operation = OP_READ;
		it.signal_sample = $urandom;
		it.trigger_sample = $urandom;
		it.manual_start = $urandom;
		it.read_level = lvl;
		it.read_index = idx;
		send(it);
	endtask

	function automatic int clamp16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	task automatic random_items(int count);
		int lvl, lim;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 3))
					0: tick($urandom, $urandom, $urandom_range(0, 19) == 0);
					1: tick($urandom, clamp16(cfg_hi + $urandom_range(0, 4) - 1),
						$urandom_range(0, 19) == 0);
					default: tick($urandom, clamp16(cfg_lo - $urandom_range(0, 4) + 1),
						$urandom_range(0, 19) == 0);
				endcase
			end else begin
				lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
				lim = (lvl == 0) ? cfg_len : (lvl <= 4 ? used_size(lvl) : 10);
				if ($urandom_range(0, 7) == 0) read_at(lvl, $urandom_range(0, 65535));
				else read_at(lvl, $urandom_range(0, (lim + 2 > 65535) ? 65535 : lim + 2));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		cfg_len = MAX_DEPTH;
		cfg_lvls = LEVELS;
		cfg_hi = 5120;
		cfg_lo = 4915;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: schmitt arming, extremes, manual restart, pulse stretch, bad reads
		configure(5, 4, 100, -100, 3);
		tick(0, 32767, 1'b0);
		tick(1, -32768, 1'b0);
		tick(-32768, 32767, 1'b0);
		tick(32767, 0, 1'b1);
		read_at(0, 0);
		tick(-1, -32768, 1'b0);
		tick(12, 32767, 1'b0);
		tick(-7, 0, 1'b0);
		read_at(0, 0);
		read_at(0, 4);
		read_at(0, 5);
		read_at(1, 0);
		read_at(1, 1);
		read_at(2, 0);
		read_at(4, 0);
		read_at(5, 0);
		read_at(7, 65535);
		read_at(0, 65535);
		tick(3, 0, 1'b1);
		tick(4, 0, 1'b0);
		tick(5, -32768, 1'b0);
		tick(6, 32767, 1'b0);
		tick(6, 0, 1'b1);
		read_at(0, 2);

		// random phases over several settings, extremes included
		configure(1, 0, 0, 0, 1);
		random_items(150);
		configure(0, 7, 32767, -32768, 0);
		random_items(150);
		configure(20, 1, 200, -200, 5);
		random_items(200);
		configure(70, 2, -50, -300, 12);
		random_items(200);
		configure(300, 4, 1000, 900, 65535);
		random_items(300);
		configure(1000, 3, 5120, 4915, 441);
		random_items(250);
		configure(131071, 4, 300, -300, 7);
		random_items(150);
		configure(17, 4, -32768, 32767, 2);
		random_items(100);

		drain();
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
